[rtl/ncas_pkg.sv]
package ncas_pkg;

	// Fixed widths of the item fields
	localparam int FIELD_BITS   = 16;
	localparam int MAX_FEATURES = 8;
	localparam int SLOT_BITS    = 4;
	localparam int INDEX_BITS   = 4;
	localparam int DIST_BITS    = 35;
	localparam int CFG_BITS     = 5;

	localparam logic [CFG_BITS-1:0] ACTIVE_RESET = 5'd16;

	// Opcodes
	localparam logic OP_LOAD     = 1'b0;
	localparam logic OP_CLASSIFY = 1'b1;

	typedef struct packed {
		logic                         opcode;
		logic [SLOT_BITS-1:0]         slot;
		logic signed [FIELD_BITS-1:0] feature_0;
		logic signed [FIELD_BITS-1:0] feature_1;
		logic signed [FIELD_BITS-1:0] feature_2;
		logic signed [FIELD_BITS-1:0] feature_3;
		logic signed [FIELD_BITS-1:0] feature_4;
		logic signed [FIELD_BITS-1:0] feature_5;
		logic signed [FIELD_BITS-1:0] feature_6;
		logic signed [FIELD_BITS-1:0] feature_7;
	} in_item_t;

	typedef struct packed {
		logic [INDEX_BITS-1:0] nearest_index;
		logic [DIST_BITS-1:0]  min_distance;
	} out_item_t;

	// Tag travelling alongside one centroid comparison
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} tag_t;

endpackage

[rtl/ncas_lane.sv]
// One feature lane: centroid column memory, difference and square.
module ncas_lane #(
	parameter int NUM_CENTROIDS = 16,
	parameter int FEATURE_BITS  = 16
) (
	input  logic                                 clk,
	input  logic                                 wr_en,
	input  logic [$clog2(NUM_CENTROIDS)-1:0]     wr_addr,
	input  logic                                 x_ld,
	input  logic [ncas_pkg::FIELD_BITS-1:0]      raw,
	input  logic [$clog2(NUM_CENTROIDS)-1:0]     rd_addr,
	output logic [2*FEATURE_BITS:0]              sq_s2
);

	localparam int EXT_BITS = (FEATURE_BITS > ncas_pkg::FIELD_BITS) ?
		FEATURE_BITS : ncas_pkg::FIELD_BITS;
	localparam int SQ_BITS = 2*FEATURE_BITS+1;

	logic [EXT_BITS-1:0]              raw_ext;
	logic signed [FEATURE_BITS-1:0]   val;
	logic signed [FEATURE_BITS-1:0]   mem_q [NUM_CENTROIDS];
	logic signed [FEATURE_BITS-1:0]   x_q;
	logic signed [FEATURE_BITS-1:0]   rd_s1;
	logic signed [FEATURE_BITS:0]     diff;
	logic signed [2*FEATURE_BITS+1:0] prod;

	// field read as signed FEATURE_BITS from its low bits
	assign raw_ext = EXT_BITS'(raw);
	assign val     = signed'(raw_ext[FEATURE_BITS-1:0]);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= val;
		end
		rd_s1 <= mem_q[rd_addr];
	end

	assign diff = (FEATURE_BITS+1)'(x_q) - (FEATURE_BITS+1)'(rd_s1);
	assign prod = (2*FEATURE_BITS+2)'(diff) * (2*FEATURE_BITS+2)'(diff);

	always_ff @(posedge clk) begin
		if (x_ld) begin
			x_q <= val;
		end
		sq_s2 <= prod[SQ_BITS-1:0];
	end

endmodule

[rtl/ncas_merge.sv]
// Sums the lane squares in a two-level registered tree, keeps the running minimum.
module ncas_merge #(
	parameter int NUM_CENTROIDS = 16,
	parameter int NUM_FEATURES  = 8,
	parameter int FEATURE_BITS  = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ncas_pkg::tag_t                   tag_s2,
	input  logic [$clog2(NUM_CENTROIDS)-1:0] k_s2,
	input  logic [2*FEATURE_BITS:0]          sq_s2 [NUM_FEATURES],
	output logic                             done_q,
	output logic [$clog2(NUM_CENTROIDS)-1:0] best_idx_q,
	output logic [2*FEATURE_BITS+3:0]        best_dist_q
);

	localparam int CW       = $clog2(NUM_CENTROIDS);
	localparam int GRP_BITS = 2*FEATURE_BITS+3;
	localparam int SUM_BITS = 2*FEATURE_BITS+4;
	localparam int NG       = (NUM_FEATURES+3)/4;

	logic [GRP_BITS-1:0] grp_d  [NG];
	logic [GRP_BITS-1:0] grp_s3 [NG];
	logic [SUM_BITS-1:0] sum_d;
	logic [SUM_BITS-1:0] sum_s4;
	logic [CW-1:0]       k_s3, k_s4;
	ncas_pkg::tag_t      tag_s3, tag_s4;

	// groups of up to four squares
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_d[g] = '0;
			for (int j = 0; j < 4; j++) begin
				if (4*g+j < NUM_FEATURES) begin
					grp_d[g] = grp_d[g] + GRP_BITS'(sq_s2[4*g+j]);
				end
			end
		end
	end

	always_comb begin
		sum_d = '0;
		for (int g = 0; g < NG; g++) begin
			sum_d = sum_d + SUM_BITS'(grp_s3[g]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
			tag_s4 <= '0;
			done_q <= 1'b0;
		end else begin
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			done_q <= tag_s4.valid && tag_s4.last;
		end
	end

	always_ff @(posedge clk) begin
		grp_s3 <= grp_d;
		k_s3   <= k_s2;
		sum_s4 <= sum_d;
		k_s4   <= k_s3;
		// strict less-than: lowest slot wins a tie
		if (tag_s4.valid && (tag_s4.first || sum_s4 < best_dist_q)) begin
			best_dist_q <= sum_s4;
			best_idx_q  <= k_s4;
		end
	end

endmodule

[rtl/nearest_centroid_assign.sv]
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    ncas_pkg::in_item_t  (load or classify item)
// out       output     out_valid / out_stall  ncas_pkg::out_item_t (one per classify item)
// cfg       input      cfg_wr_en              cfg_wr_data (active_centroids)
//
// A load item is written into the lane memories at acceptance.
// A classify item keeps the input stalled until its result is taken into the output register;
// N rows are compared, N being active_centroids saturated to 1 .. NUM_CENTROIDS; one centroid row per cycle.
// Reset clears control and sets active_centroids to 16; the centroid table is not cleared.
// in_stall is high while a classify item is in flight; a result finding the output register
// still stalled waits in pend_q and keeps the block busy until the register is taken.
module nearest_centroid_assign #(
	parameter int NUM_CENTROIDS = 16,
	parameter int NUM_FEATURES  = 8,
	parameter int FEATURE_BITS  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  ncas_pkg::in_item_t                 in_item,
	output logic                               out_valid,
	input  logic                               out_stall,
	output ncas_pkg::out_item_t                out_item,
	input  logic                               cfg_wr_en,
	input  logic [ncas_pkg::CFG_BITS-1:0]      cfg_wr_data
);

	localparam int CW       = $clog2(NUM_CENTROIDS);
	localparam int SQ_BITS  = 2*FEATURE_BITS+1;
	localparam int SUM_BITS = 2*FEATURE_BITS+4;

	logic [ncas_pkg::CFG_BITS-1:0]   active_q;
	logic                            busy_q;
	logic                            issuing_q;
	logic                            pend_q;
	logic                            out_valid_q;
	ncas_pkg::out_item_t             out_item_q;
	logic [CW-1:0]                   k_q, last_k_q, last_k_d;
	logic [CW-1:0]                   k_s1, k_s2;
	ncas_pkg::tag_t                  tag_s1, tag_s2;

	logic                            in_acc;
	logic                            is_load, is_cls, slot_ok;
	logic [CW-1:0]                   wr_addr;
	logic [ncas_pkg::FIELD_BITS-1:0] feat_raw [ncas_pkg::MAX_FEATURES];
	logic [SQ_BITS-1:0]              sq_s2 [NUM_FEATURES];

	logic                            merge_done;
	logic [CW-1:0]                   best_idx;
	logic [SUM_BITS-1:0]             best_dist;
	logic                            out_free, res_rdy;

	assign in_stall  = busy_q;
	assign in_acc    = in_valid && !in_stall;
	assign is_load   = in_acc && (in_item.opcode == ncas_pkg::OP_LOAD);
	assign is_cls    = in_acc && (in_item.opcode == ncas_pkg::OP_CLASSIFY);
	// loads beyond the table are dropped
	assign slot_ok   = int'(in_item.slot) < NUM_CENTROIDS;
	assign wr_addr   = CW'(in_item.slot);

	assign feat_raw[0] = in_item.feature_0;
	assign feat_raw[1] = in_item.feature_1;
	assign feat_raw[2] = in_item.feature_2;
	assign feat_raw[3] = in_item.feature_3;
	assign feat_raw[4] = in_item.feature_4;
	assign feat_raw[5] = in_item.feature_5;
	assign feat_raw[6] = in_item.feature_6;
	assign feat_raw[7] = in_item.feature_7;

	// last slot to compare: zero counts as one, large counts saturate
	always_comb begin
		if (active_q == '0) begin
			last_k_d = '0;
		end else if (int'(active_q) > NUM_CENTROIDS) begin
			last_k_d = CW'(NUM_CENTROIDS - 1);
		end else begin
			last_k_d = CW'(active_q - 5'd1);
		end
	end

	// ---------------------------------------------------------------- lanes
	for (genvar f = 0; f < NUM_FEATURES; f++) begin : g_lane
		ncas_lane #(
			.NUM_CENTROIDS (NUM_CENTROIDS),
			.FEATURE_BITS  (FEATURE_BITS)
		) u_lane (
			.clk     (clk),
			.wr_en   (is_load && slot_ok),
			.wr_addr (wr_addr),
			.x_ld    (is_cls),
			.raw     (feat_raw[f]),
			.rd_addr (k_q),
			.sq_s2   (sq_s2[f])
		);
	end

	// ---------------------------------------------------------------- merge
	ncas_merge #(
		.NUM_CENTROIDS (NUM_CENTROIDS),
		.NUM_FEATURES  (NUM_FEATURES),
		.FEATURE_BITS  (FEATURE_BITS)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.tag_s2      (tag_s2),
		.k_s2        (k_s2),
		.sq_s2       (sq_s2),
		.done_q      (merge_done),
		.best_idx_q  (best_idx),
		.best_dist_q (best_dist)
	);

	// ---------------------------------------------------------------- sequencer and output
	assign out_free = !out_valid_q || !out_stall;
	assign res_rdy  = merge_done || pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= ncas_pkg::ACTIVE_RESET;
			busy_q      <= 1'b0;
			issuing_q   <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			k_q         <= '0;
			last_k_q    <= '0;
			tag_s1      <= '0;
			tag_s2      <= '0;
		end else begin
			if (cfg_wr_en) begin
				active_q <= cfg_wr_data;
			end

			if (is_cls) begin
				busy_q    <= 1'b1;
				issuing_q <= 1'b1;
				k_q       <= '0;
				last_k_q  <= last_k_d;
			end else if (issuing_q) begin
				k_q <= k_q + CW'(1);
				if (k_q == last_k_q) begin
					issuing_q <= 1'b0;
				end
			end

			tag_s1.valid <= issuing_q;
			tag_s1.first <= issuing_q && (k_q == '0);
			tag_s1.last  <= issuing_q && (k_q == last_k_q);
			tag_s2       <= tag_s1;

			// result waits in pend_q while the output register is stalled
			if (res_rdy && out_free) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
				busy_q      <= 1'b0;
			end else if (merge_done) begin
				pend_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		k_s1 <= k_q;
		k_s2 <= k_s1;
		if (res_rdy && out_free) begin
			out_item_q.nearest_index <= 4'(best_idx);
			out_item_q.min_distance  <= 35'(best_dist);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// ---------------------------------------------------------------- assertions
	a_issue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		issuing_q |-> busy_q)
		else $error("row issue outside a classify item");

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		issuing_q |-> (k_q <= last_k_q))
		else $error("row counter past last active slot");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		merge_done |-> (busy_q && !issuing_q))
		else $error("merge finished with no item in flight");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(merge_done || pend_q))
		else $error("result shown without a finished comparison");

	a_pend_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> out_valid_q)
		else $error("result held back while output register empty");

endmodule
